/* hdl/dtte_pkg.sv */
// shared widths, constants and the parsed date record for the date-time parser
package dtte_pkg;

    // character position counter
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] LAST_POS = 5'd19;

    // field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned FIELD_W = 7;
    localparam int unsigned SECS_W  = 39;

    // request queue between parser and arithmetic back end
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one fully parsed text
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic               ok;
    } date_fields_t;

endpackage

/* hdl/dtte_channels.sv */
// valid/ready channel interfaces for characters in and epoch results out

interface dtte_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       starts_string;

    modport source (output valid, output char_code, output starts_string, input ready);
    modport sink   (input valid, input char_code, input starts_string, output ready);
endinterface

interface dtte_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [dtte_pkg::SECS_W-1:0] epoch_seconds;
    logic                             format_ok;

    modport source (output valid, output epoch_seconds, output format_ok, input ready);
    modport sink   (input valid, input epoch_seconds, input format_ok, output ready);
endinterface

/* hdl/dtte_front.sv */
// character parser: tracks position, checks digits and accumulates the six fields
module dtte_front (
    input  logic                   clk,
    input  logic                   rst_n,
    dtte_char_if.sink              char_in,
    input  logic                   queue_full,
    output logic                   push_valid,
    output dtte_pkg::date_fields_t push_data
);

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [2:0] {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_SEP
    } field_sel_t;

    logic [dtte_pkg::POS_W-1:0]   pos_reg, pos_next, pos_base;
    logic                         ok_reg, ok_next, ok_base;
    logic [dtte_pkg::YEAR_W-1:0]  year_reg, year_next, year_base;
    logic [dtte_pkg::FIELD_W-1:0] month_reg, month_next, month_base;
    logic [dtte_pkg::FIELD_W-1:0] day_reg, day_next, day_base;
    logic [dtte_pkg::FIELD_W-1:0] hour_reg, hour_next, hour_base;
    logic [dtte_pkg::FIELD_W-1:0] minute_reg, minute_next, minute_base;
    logic [dtte_pkg::FIELD_W-1:0] second_reg, second_next, second_base;

    logic       accept;
    logic       active;
    logic       is_digit;
    logic [3:0] digit;
    field_sel_t field_sel;

    // push one decimal digit into a two-digit field, wrapped to the field width
    function automatic logic [dtte_pkg::FIELD_W-1:0] push_digit(
        input logic [dtte_pkg::FIELD_W-1:0] value,
        input logic [3:0]                   d
    );
        logic [dtte_pkg::FIELD_W+3:0] wide;
        wide = {4'b0, value} * 11'd10 + {7'b0, d};
        return wide[dtte_pkg::FIELD_W-1:0];
    endfunction

    // which field a position feeds
    function automatic field_sel_t field_of(input logic [dtte_pkg::POS_W-1:0] pos);
        field_sel_t sel;
        unique case (pos) inside
            [5'd0:5'd3]:       sel = FLD_YEAR;
            5'd5, 5'd6:        sel = FLD_MONTH;
            5'd8, 5'd9:        sel = FLD_DAY;
            5'd11, 5'd12:      sel = FLD_HOUR;
            5'd14, 5'd15:      sel = FLD_MINUTE;
            5'd17, 5'd18:      sel = FLD_SECOND;
            default:           sel = FLD_SEP;
        endcase
        return sel;
    endfunction

    assign char_in.ready = !queue_full;
    assign accept        = char_in.valid && char_in.ready;
    assign active        = accept && (char_in.starts_string || (pos_reg < dtte_pkg::LAST_POS));

    // digit decode
    assign is_digit = (char_in.char_code >= CHAR_ZERO) && (char_in.char_code <= CHAR_NINE);
    assign digit    = is_digit ? char_in.char_code[3:0] : 4'd0;

    // a start flag clears the partial text
    always_comb
    begin
        if (char_in.starts_string)
        begin
            pos_base    = '0;
            ok_base     = 1'b1;
            year_base   = '0;
            month_base  = '0;
            day_base    = '0;
            hour_base   = '0;
            minute_base = '0;
            second_base = '0;
        end
        else
        begin
            pos_base    = pos_reg;
            ok_base     = ok_reg;
            year_base   = year_reg;
            month_base  = month_reg;
            day_base    = day_reg;
            hour_base   = hour_reg;
            minute_base = minute_reg;
            second_base = second_reg;
        end
    end

    assign field_sel = field_of(pos_base);

    // field accumulation for the current character
    always_comb
    begin
        logic [dtte_pkg::YEAR_W+3:0] year_wide;
        year_wide   = {4'b0, year_base} * 18'd10 + {14'b0, digit};
        pos_next    = pos_reg;
        ok_next     = ok_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (active)
        begin
            pos_next    = pos_base + 5'd1;
            ok_next     = ok_base && (is_digit || (field_sel == FLD_SEP));
            year_next   = year_base;
            month_next  = month_base;
            day_next    = day_base;
            hour_next   = hour_base;
            minute_next = minute_base;
            second_next = second_base;
            case (field_sel)
                FLD_YEAR:   year_next   = year_wide[dtte_pkg::YEAR_W-1:0];
                FLD_MONTH:  month_next  = push_digit(month_base, digit);
                FLD_DAY:    day_next    = push_digit(day_base, digit);
                FLD_HOUR:   hour_next   = push_digit(hour_base, digit);
                FLD_MINUTE: minute_next = push_digit(minute_base, digit);
                FLD_SECOND: second_next = push_digit(second_base, digit);
                default:    ;
            endcase
        end
    end

    // hand the record over on the last character
    assign push_valid       = active && (pos_base == dtte_pkg::LAST_POS - 5'd1);
    assign push_data.year   = year_next;
    assign push_data.month  = month_next;
    assign push_data.day    = day_next;
    assign push_data.hour   = hour_next;
    assign push_data.minute = minute_next;
    assign push_data.second = second_next;
    assign push_data.ok     = ok_next;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= dtte_pkg::LAST_POS;
            ok_reg     <= 1'b1;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            ok_reg     <= ok_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

endmodule

/* hdl/dtte_queue.sv */
// short queue of parsed records between parser and arithmetic back end
module dtte_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  dtte_pkg::date_fields_t push_data,
    output logic                   full,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output dtte_pkg::date_fields_t pop_data
);

    localparam logic [dtte_pkg::QCNT_W-1:0] DEPTH_CNT = dtte_pkg::QCNT_W'(dtte_pkg::QUEUE_DEPTH);
    localparam logic [dtte_pkg::QPTR_W-1:0] LAST_PTR  = dtte_pkg::QPTR_W'(dtte_pkg::QUEUE_DEPTH - 1);

    dtte_pkg::date_fields_t           entry_reg [dtte_pkg::QUEUE_DEPTH];
    logic [dtte_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [dtte_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [dtte_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !full)
        else $error("record pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue fill count beyond depth");
`endif

endmodule

/* hdl/dtte_back.sv */
// arithmetic back end: turns a parsed record into seconds since the epoch
module dtte_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  dtte_pkg::date_fields_t pop_data,
    dtte_result_if.source          result_out
);

    localparam int unsigned DAYS_W = 24;
    localparam int unsigned HMS_W  = 19;
    localparam int unsigned QUOT_W = 8;

    localparam logic [dtte_pkg::YEAR_W-1:0] EPOCH_YEAR         = 14'd1970;
    localparam logic [DAYS_W-1:0]           LEAPS_BEFORE_EPOCH = 24'd477;
    localparam logic [12:0]                 DIV100_MUL         = 13'd5243;
    localparam int unsigned                 DIV100_SHIFT       = 19;
    localparam logic signed [17:0]          SECS_PER_DAY       = 18'sd86400;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DAYS,
        ST_SECS
    } state_t;

    state_t state_reg, state_next;

    dtte_pkg::date_fields_t       rec_reg;
    logic [QUOT_W-1:0]            q_year_reg;
    logic [QUOT_W-1:0]            q_prev_reg;
    logic [DAYS_W-1:0]            year365_reg;
    logic [HMS_W-1:0]             hms_reg;
    logic signed [DAYS_W-1:0]     days_reg;
    logic                         out_valid_reg;
    logic signed [dtte_pkg::SECS_W-1:0] epoch_reg;
    logic                         ok_out_reg;

    logic [dtte_pkg::YEAR_W-1:0]  year_prev;
    logic [26:0]                  prod_year;
    logic [26:0]                  prod_prev;
    logic [dtte_pkg::YEAR_W-1:0]  years_since;
    logic [HMS_W-1:0]             hms_calc;
    logic [DAYS_W-1:0]            year_days;
    logic [DAYS_W-1:0]            days_calc;
    logic [3:0]                   full_months;
    logic [dtte_pkg::FIELD_W-1:0] month_less;
    logic [14:0]                  century_mul;
    logic                         leap;
    logic signed [41:0]           day_secs;
    logic [dtte_pkg::SECS_W-1:0]  epoch_calc;
    logic                         out_free;

    // days in the months before the given count of full months, common year
    function automatic logic [8:0] days_before(input logic [3:0] months);
        logic [8:0] d;
        unique case (months)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    // divide stage: year and year-1 over 100 by reciprocal, days of whole years, time of day
    assign year_prev   = rec_reg.year - 14'd1;
    assign prod_year   = {13'b0, rec_reg.year} * {14'b0, DIV100_MUL};
    assign prod_prev   = {13'b0, year_prev} * {14'b0, DIV100_MUL};
    assign years_since = rec_reg.year - EPOCH_YEAR;
    assign hms_calc    = {12'b0, rec_reg.hour} * 19'd3600
                       + {12'b0, rec_reg.minute} * 19'd60
                       + {12'b0, rec_reg.second};

    // days stage: leap corrections, months and day of month
    assign century_mul = {7'b0, q_year_reg} * 15'd100;
    assign leap = ((rec_reg.year[1:0] == 2'b00) && ({1'b0, rec_reg.year} != century_mul))
               || (({1'b0, rec_reg.year} == century_mul) && (q_year_reg[1:0] == 2'b00));
    assign month_less = rec_reg.month - 7'd1;

    always_comb
    begin
        if (rec_reg.month <= 7'd1)
            full_months = 4'd0;
        else if (month_less > 7'd12)
            full_months = 4'd12;
        else
            full_months = month_less[3:0];
    end

    always_comb
    begin
        if (rec_reg.year > EPOCH_YEAR)
            year_days = year365_reg
                      + {12'b0, year_prev[dtte_pkg::YEAR_W-1:2]}
                      - {16'b0, q_prev_reg}
                      + {18'b0, q_prev_reg[QUOT_W-1:2]}
                      - LEAPS_BEFORE_EPOCH;
        else
            year_days = '0;
    end

    assign days_calc = year_days
                     + {15'b0, days_before(full_months)}
                     + {23'b0, (leap && (full_months >= 4'd2))}
                     + {17'b0, rec_reg.day}
                     - 24'd1;

    // seconds stage
    assign day_secs   = days_reg * SECS_PER_DAY;
    assign epoch_calc = rec_reg.ok ? (day_secs[dtte_pkg::SECS_W-1:0] + {20'b0, hms_reg}) : '0;
    assign out_free   = !out_valid_reg || result_out.ready;

    assign pop_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (pop_valid) state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = ST_DAYS;
            ST_DAYS:   state_next = ST_SECS;
            ST_SECS:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state, working registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rec_reg       <= '0;
            q_year_reg    <= '0;
            q_prev_reg    <= '0;
            year365_reg   <= '0;
            hms_reg       <= '0;
            days_reg      <= '0;
            out_valid_reg <= 1'b0;
            epoch_reg     <= '0;
            ok_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && pop_valid)
                rec_reg <= pop_data;
            if (state_reg == ST_DIVIDE)
            begin
                q_year_reg  <= prod_year[DIV100_SHIFT +: QUOT_W];
                q_prev_reg  <= prod_prev[DIV100_SHIFT +: QUOT_W];
                year365_reg <= {10'b0, years_since} * 24'd365;
                hms_reg     <= hms_calc;
            end
            if (state_reg == ST_DAYS)
                days_reg <= $signed(days_calc);
            if ((state_reg == ST_SECS) && out_free)
            begin
                out_valid_reg <= 1'b1;
                epoch_reg     <= $signed(epoch_calc);
                ok_out_reg    <= rec_reg.ok;
            end
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.epoch_seconds = epoch_reg;
    assign result_out.format_ok     = ok_out_reg;

`ifndef SYNTHESIS
    a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_out_reg) |-> (epoch_reg == '0))
        else $error("format error result carries nonzero seconds");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (state_reg == ST_DIVIDE))
        else $error("accepted record did not start the sequence");

    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SECS) && out_free) |=> out_valid_reg)
        else $error("finished record did not reach the result register");
`endif

endmodule

/* hdl/datetime_text_to_epoch_seconds.sv */
// Top level of the date-time text to epoch seconds converter.
// Characters of a "YYYY-MM-DD HH:MM:SS" text arrive one per request, the
// first flagged by starts_string; one is taken every cycle unless the queue
// is full. After the nineteenth character one result follows: seconds since
// 1970-01-01 00:00:00 (Gregorian leap years), or 0 with format_ok low when a
// digit position held something else. The parser hands each finished text
// to a two-record queue; the arithmetic back end works on one record at a
// time in four steps (take, divide by 100, sum days, scale to seconds), each
// ending in its own register, so the back end is free again long before the
// next text can be complete. The input stalls only when both queue slots are
// taken while the result waits.
module datetime_text_to_epoch_seconds (
    input  logic          clk,
    input  logic          rst_n,
    dtte_char_if.sink     char_in,
    dtte_result_if.source result_out
);

    logic                   push_valid;
    dtte_pkg::date_fields_t push_data;
    logic                   queue_full;
    logic                   pop_valid;
    logic                   pop_ready;
    dtte_pkg::date_fields_t pop_data;

    // character parser
    dtte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // record queue
    dtte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // seconds arithmetic
    dtte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .result_out (result_out)
    );

endmodule

/* tb/tb_datetime_text_to_epoch_seconds.sv */
// self-checking testbench for the date-time text to epoch seconds converter
`timescale 1ns / 1ps

module tb_datetime_text_to_epoch_seconds;

    localparam int unsigned TEXT_LEN      = 19;
    localparam int unsigned RANDOM_CHARS  = 500;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam longint      DAY_SECONDS   = 86400;
    localparam longint      HOUR_SECONDS  = 3600;
    localparam longint      MINUTE_SECONDS = 60;
    localparam logic [7:0]  CH_ZERO       = 8'h30;
    localparam logic [7:0]  CH_NINE       = 8'h39;
    localparam int          MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int          DIGIT_SLOTS [14] = '{0, 1, 2, 3, 5, 6, 8, 9, 11, 12, 14, 15, 17, 18};

    typedef struct packed {
        logic [7:0] code;
        logic       first;
    } text_char_t;

    typedef struct packed {
        logic [dtte_pkg::SECS_W-1:0] secs;
        logic                        ok;
    } epoch_result_t;

    logic clk;
    logic rst_n;

    dtte_char_if   char_ch ();
    dtte_result_if result_ch ();

    datetime_text_to_epoch_seconds u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch),
        .result_out (result_ch)
    );

    // characters waiting to be sent and epochs waiting to come back
    text_char_t    text_chars [$];
    epoch_result_t pending_epochs [$];

    int unsigned chars_queued;
    int unsigned chars_taken;
    int unsigned results_seen;
    int unsigned mismatch_count;
    bit          char_taken;

    int send_idle;
    int send_burst;
    int take_idle;
    int take_burst;
    int hold_left;
    int holds_done;

    // parser state of the predictor
    logic [dtte_pkg::POS_W-1:0]   parse_pos;
    bit                           digits_ok;
    logic [dtte_pkg::YEAR_W-1:0]  year_acc;
    logic [dtte_pkg::FIELD_W-1:0] month_acc;
    logic [dtte_pkg::FIELD_W-1:0] day_acc;
    logic [dtte_pkg::FIELD_W-1:0] hour_acc;
    logic [dtte_pkg::FIELD_W-1:0] minute_acc;
    logic [dtte_pkg::FIELD_W-1:0] second_acc;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // leap years from year 1 up to and including n
    function automatic longint leaps_upto(input int unsigned n);
        return longint'(n / 4) - longint'(n / 100) + longint'(n / 400);
    endfunction

    function automatic longint seconds_since_epoch();
        longint      days;
        int unsigned y;
        int unsigned full_months;
        days = 0;
        y = year_acc;
        // whole years after the epoch year
        if (y > EPOCH_YEAR)
            days = 365 * longint'(y - EPOCH_YEAR) + leaps_upto(y - 1) - leaps_upto(EPOCH_YEAR - 1);
        // whole months, capped at a full year
        if (month_acc > 1)
        begin
            full_months = month_acc - 1;
            if (full_months > 12)
                full_months = 12;
            for (int i = 0; i < full_months; i++)
            begin
                days += MONTH_LEN[i];
                if (i == 1 && is_leap(y))
                    days += 1;
            end
        end
        days += longint'(day_acc) - 1;
        return days * DAY_SECONDS + longint'(hour_acc) * HOUR_SECONDS
             + longint'(minute_acc) * MINUTE_SECONDS + longint'(second_acc);
    endfunction

    // advance the parser by one character, 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, input logic first,
                                      output epoch_result_t res);
        bit          is_digit;
        bit          digit_slot;
        logic [3:0]  d;
        int unsigned p;
        res = '0;
        if (first)
        begin
            parse_pos  = '0;
            digits_ok  = 1'b1;
            year_acc   = '0;
            month_acc  = '0;
            day_acc    = '0;
            hour_acc   = '0;
            minute_acc = '0;
            second_acc = '0;
        end
        else if (parse_pos >= dtte_pkg::LAST_POS)
        begin
            return 1'b0;
        end
        is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        d          = is_digit ? 4'(c - CH_ZERO) : 4'd0;
        digit_slot = 1'b1;
        p          = parse_pos;
        case (p)
            0, 1, 2, 3: year_acc   = year_acc * 10 + d;
            5, 6:       month_acc  = month_acc * 10 + d;
            8, 9:       day_acc    = day_acc * 10 + d;
            11, 12:     hour_acc   = hour_acc * 10 + d;
            14, 15:     minute_acc = minute_acc * 10 + d;
            17, 18:     second_acc = second_acc * 10 + d;
            default:    digit_slot = 1'b0;
        endcase
        if (digit_slot && !is_digit)
            digits_ok = 1'b0;
        parse_pos = dtte_pkg::POS_W'(p + 1);
        if (parse_pos < dtte_pkg::LAST_POS)
            return 1'b0;
        if (digits_ok)
        begin
            res.secs = dtte_pkg::SECS_W'(seconds_since_epoch());
            res.ok   = 1'b1;
        end
        return 1'b1;
    endfunction

    // idle length: mostly short, a few long, with bursts of none
    function automatic int idle_len(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    function automatic int pick_field(input int lo, input int hi, input int top);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(lo, hi);
        return $urandom_range(0, top);
    endfunction

    function automatic void write_digits(inout logic [7:0] txt [TEXT_LEN], input int pos,
                                         input int n, input int value);
        for (int k = n - 1; k >= 0; k--)
        begin
            txt[pos + k] = CH_ZERO + 8'(value % 10);
            value = value / 10;
        end
    endfunction

    function automatic void text_from_string(input string s, output logic [7:0] txt [TEXT_LEN]);
        for (int i = 0; i < TEXT_LEN; i++)
            txt[i] = s[i];
    endfunction

    task automatic push_char(input logic [7:0] c, input logic first);
        text_chars.push_back('{code: c, first: first});
        chars_queued++;
    endtask

    task automatic push_text_bytes(input logic [7:0] txt [TEXT_LEN], input int len);
        for (int i = 0; i < len; i++)
            push_char(txt[i], i == 0);
    endtask

    task automatic push_text(input string s);
        logic [7:0] txt [TEXT_LEN];
        text_from_string(s, txt);
        push_text_bytes(txt, TEXT_LEN);
    endtask

    // random date text, mostly plausible values, odd separators now and then
    task automatic make_random_date(output logic [7:0] txt [TEXT_LEN]);
        int r;
        int year;
        text_from_string("0000-00-00 00:00:00", txt);
        r = $urandom_range(0, 99);
        if (r < 60)
            year = $urandom_range(1970, 2100);
        else if (r < 80)
            year = $urandom_range(1600, 2400);
        else
            year = $urandom_range(0, 9999);
        write_digits(txt, 0, 4, year);
        write_digits(txt, 5, 2, pick_field(1, 12, 99));
        write_digits(txt, 8, 2, pick_field(1, 31, 99));
        write_digits(txt, 11, 2, pick_field(0, 23, 99));
        write_digits(txt, 14, 2, pick_field(0, 59, 99));
        write_digits(txt, 17, 2, pick_field(0, 59, 99));
        for (int s = 4; s < TEXT_LEN; s += 3)
            if ($urandom_range(0, 99) < 20)
                txt[s] = 8'($urandom_range(0, 255));
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [7:0] txt [TEXT_LEN];
        int         kind;
        int         len;
        int unsigned counted;

        rst_n                   = 1'b0;
        char_ch.valid           = 1'b0;
        char_ch.char_code       = '0;
        char_ch.starts_string   = 1'b0;
        result_ch.ready         = 1'b0;
        chars_queued            = 0;
        chars_taken             = 0;
        results_seen            = 0;
        mismatch_count          = 0;
        char_taken              = 1'b0;
        send_idle               = 0;
        send_burst              = 0;
        take_idle               = 0;
        take_burst              = 0;
        hold_left               = 0;
        holds_done              = 0;
        parse_pos               = dtte_pkg::LAST_POS;
        digits_ok               = 1'b1;
        year_acc                = '0;
        month_acc               = '0;
        day_acc                 = '0;
        hour_acc                = '0;
        minute_acc              = '0;
        second_acc              = '0;

        // noise while idle is ignored
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(CH_ZERO + 8'd5, 1'b0);
        // epoch itself, then trailing characters that must be ignored
        push_text("1970-01-01 00:00:00");
        push_char(8'h78, 1'b0);
        push_char(CH_NINE, 1'b0);
        // largest fields, all-zero text with day zero, leap year rules
        push_text("9999-99-99 99:99:99");
        push_text("0000-00-00 00:00:00");
        push_text("2000-03-01 12:34:56");
        push_text("2100-03-01 00:00:00");
        push_text("2024-02-29 23:59:59");
        // year before the epoch with a month past december
        push_text("1969-13-05 01:02:03");
        push_text("2023-12-31 23:59:59");
        // non-digits at digit positions, just outside the digit range too
        push_text("2023-0a-15 10:00:00");
        push_text("2023-01-15 1/:00:00");
        push_text("2023-01-15 10:00:0:");
        // restart in mid text
        text_from_string("2023-05-17 08:09:10", txt);
        push_text_bytes(txt, 7);
        push_text_bytes(txt, TEXT_LEN);
        // separators are not checked
        text_from_string("2023-06-15 07:12:30", txt);
        txt[4]  = 8'hFF;
        txt[7]  = 8'h00;
        txt[10] = 8'h80;
        txt[13] = CH_ZERO;
        txt[16] = 8'h7F;
        push_text_bytes(txt, TEXT_LEN);
        // start flag on a non-digit
        text_from_string("#023-06-15 07:12:30", txt);
        push_text_bytes(txt, TEXT_LEN);

        // random texts: mostly well formed, some broken or noisy
        counted = 0;
        while (counted < RANDOM_CHARS)
        begin
            make_random_date(txt);
            kind = $urandom_range(0, 99);
            len  = TEXT_LEN;
            if (kind < 12)
                txt[DIGIT_SLOTS[$urandom_range(0, 13)]] = random_non_digit();
            else if (kind < 22)
                len = $urandom_range(1, TEXT_LEN - 1);
            push_text_bytes(txt, len);
            counted += len;
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 4))
                    push_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain
        wait (chars_taken == chars_queued);
        wait (pending_epochs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // character driver
    always @(negedge clk)
    begin : char_driver
        text_char_t next_char;
        if (!rst_n)
        begin
            char_ch.valid <= 1'b0;
        end
        else if (!char_ch.valid || char_taken)
        begin
            if (send_idle > 0)
            begin
                send_idle--;
                char_ch.valid <= 1'b0;
            end
            else if (text_chars.size() > 0)
            begin
                next_char = text_chars.pop_front();
                char_ch.valid         <= 1'b1;
                char_ch.char_code     <= next_char.code;
                char_ch.starts_string <= next_char.first;
                send_idle = idle_len(send_burst);
            end
            else
            begin
                char_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with long hold-offs to fill the block up
    always @(negedge clk)
    begin : result_sink
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 8 : 30))
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            result_ch.ready <= 1'b0;
        end
        else if (take_idle > 0)
        begin
            take_idle--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            take_idle = idle_len(take_burst);
        end
    end

    // monitor: check results, predict from accepted characters
    always @(posedge clk)
    begin : monitor
        epoch_result_t want;
        epoch_result_t calc;
        char_taken = rst_n && char_ch.valid && char_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (pending_epochs.size() == 0)
            begin
                report_failure($sformatf("unexpected result epoch_seconds %0d format_ok %0b",
                                         result_ch.epoch_seconds, result_ch.format_ok));
            end
            else
            begin
                want = pending_epochs.pop_front();
                if (result_ch.epoch_seconds !== want.secs)
                    report_failure($sformatf("epoch_seconds: expected %0d, got %0d",
                                             $signed(want.secs), result_ch.epoch_seconds));
                if (result_ch.format_ok !== want.ok)
                    report_failure($sformatf("format_ok: expected %0b, got %0b",
                                             want.ok, result_ch.format_ok));
            end
        end
        if (char_taken)
        begin
            chars_taken++;
            if (parse_char(char_ch.char_code, char_ch.starts_string, calc))
                pending_epochs.push_back(calc);
        end
    end

endmodule
